[rtl/sdbf_pkg.sv]
// ----------------------------------------------------------------------------
// sdbf_pkg
// Shared types, constants and functions of the data block framer.
// ----------------------------------------------------------------------------
package sdbf_pkg;

	localparam int unsigned CFG_W          = 7;
	localparam int unsigned CFG_IDX_W      = 2;
	localparam int unsigned GROUP_SIZE     = 7;
	localparam int unsigned SEQ_W          = 14;
	localparam int unsigned QUEUE_DEPTH_DEF = 2;

	localparam logic [CFG_IDX_W-1:0] REG_MANUFACTURER = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DEVICE       = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BLOCK_TYPE   = 2'd2;

	localparam logic [CFG_W-1:0] MANUFACTURER_RST = 7'd125;
	localparam logic [CFG_W-1:0] DEVICE_RST       = 7'd0;
	localparam logic [CFG_W-1:0] BLOCK_TYPE_RST   = 7'd4;

	localparam logic [7:0] SOX_BYTE = 8'hF0;
	localparam logic [7:0] EOX_BYTE = 8'hF7;
	localparam logic [7:0] CRC_POLY = 8'h07;

	typedef struct packed {
		logic [CFG_W-1:0] manufacturer_id;
		logic [CFG_W-1:0] device_id;
		logic [CFG_W-1:0] block_type;
	} cfg_t;

	typedef struct packed {
		logic                 hdr;
		logic [SEQ_W-1:0]     seq;
		logic                 grp;
		logic [6:0]           top;
		logic [6:0][6:0]      bytes;
		logic [2:0]           cnt;
		logic                 fin;
		logic [7:0]           crc;
	} cmd_t;

	function automatic logic [7:0] crc8_byte(input logic [7:0] c, input logic [7:0] d);
		logic [7:0] r;
		r = c ^ d;
		for (int b = 0; b < 8; b++) begin
			if (r[7]) begin
				r = {r[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				r = {r[6:0], 1'b0};
			end
		end
		return r;
	endfunction

endpackage

[rtl/sdbf_front.sv]
// ----------------------------------------------------------------------------
// sdbf_front
// Accepts raw bytes, keeps the CRC and the pending group, and issues commands.
// ----------------------------------------------------------------------------
module sdbf_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [7:0]            data_byte,
	input  logic [sdbf_pkg::SEQ_W-1:0] seq_number,
	input  logic                  last_byte,
	input  logic                  q_full,
	output logic                  push,
	output sdbf_pkg::cmd_t        cmd
);
	import sdbf_pkg::*;

	logic            inmsg_q;
	logic [2:0]      fill_q;
	logic [6:0]      top_q;
	logic [7:0]      crc_q;
	logic [6:0][6:0] grp_q;

	logic            accept;
	logic [2:0]      fill0;
	logic [2:0]      fill_n;
	logic [6:0]      top_n;
	logic [7:0]      crc_n;
	logic [6:0][6:0] grp_n;
	logic            close;

	always_comb begin
		fill0  = inmsg_q ? fill_q : 3'd0;
		crc_n  = crc8_byte(inmsg_q ? crc_q : 8'd0, data_byte);
		top_n  = (inmsg_q ? top_q : 7'd0) | (7'(data_byte[7]) << fill0);
		grp_n  = grp_q;
		grp_n[fill0] = data_byte[6:0];
		fill_n = fill0 + 3'd1;
		close  = (fill_n == 3'(GROUP_SIZE)) || last_byte;
	end

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign push     = accept && (!inmsg_q || close);

	always_comb begin
		cmd.hdr   = !inmsg_q;
		cmd.seq   = seq_number;
		cmd.grp   = close;
		cmd.top   = top_n;
		cmd.bytes = grp_n;
		cmd.cnt   = fill_n;
		cmd.fin   = last_byte;
		cmd.crc   = crc_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inmsg_q <= 1'b0;
			fill_q  <= 3'd0;
			top_q   <= 7'd0;
			crc_q   <= 8'd0;
		end else if (accept) begin
			inmsg_q <= !last_byte;
			fill_q  <= close ? 3'd0 : fill_n;
			top_q   <= close ? 7'd0 : top_n;
			crc_q   <= last_byte ? 8'd0 : crc_n;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			grp_q[fill0] <= data_byte[6:0];
		end
	end

endmodule

[rtl/sdbf_queue.sv]
// ----------------------------------------------------------------------------
// sdbf_queue
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module sdbf_queue #(
	parameter int unsigned DEPTH = sdbf_pkg::QUEUE_DEPTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  sdbf_pkg::cmd_t wr_cmd,
	input  logic           pop,
	output sdbf_pkg::cmd_t head,
	output logic           empty,
	output logic           full
);
	import sdbf_pkg::*;

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	cmd_t          mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
		return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
	endfunction

	assign empty = (count_q == '0);
	assign full  = (count_q == CW'(DEPTH));
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_cmd;
		end
	end

endmodule

[rtl/sdbf_back.sv]
// ----------------------------------------------------------------------------
// sdbf_back
// Walks each command byte by byte and drives the registered output stream.
// ----------------------------------------------------------------------------
module sdbf_back (
	input  logic           clk,
	input  logic           arst_n,
	input  sdbf_pkg::cfg_t cfg,
	input  sdbf_pkg::cmd_t head,
	input  logic           empty,
	output logic           pop,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [7:0]     out_byte,
	output logic           run_end,
	output logic           message_end
);
	import sdbf_pkg::*;

	localparam logic [3:0] IDX_SOX  = 4'd0;
	localparam logic [3:0] IDX_MFR  = 4'd1;
	localparam logic [3:0] IDX_DEV  = 4'd2;
	localparam logic [3:0] IDX_TYPE = 4'd3;
	localparam logic [3:0] IDX_SEQH = 4'd4;
	localparam logic [3:0] IDX_SEQL = 4'd5;
	localparam logic [3:0] IDX_TOP  = 4'd6;
	localparam logic [3:0] IDX_G0   = 4'd7;
	localparam logic [3:0] IDX_G6   = 4'd13;
	localparam logic [3:0] IDX_CRC  = 4'd14;
	localparam logic [3:0] IDX_EOX  = 4'd15;

	logic       mid_q;
	logic [3:0] idx_q;
	logic       ov_q;
	logic [7:0] ob_q;
	logic       orun_q;
	logic       oend_q;

	logic       emit;
	logic [3:0] cur;
	logic [3:0] nxt;
	logic       done;
	logic [2:0] k;
	logic [7:0] sel;

	always_comb begin
		if (mid_q) begin
			cur = idx_q;
		end else if (head.hdr) begin
			cur = IDX_SOX;
		end else if (head.grp) begin
			cur = IDX_TOP;
		end else begin
			cur = IDX_CRC;
		end
		k    = 3'(cur - IDX_G0);
		nxt  = cur + 4'd1;
		done = 1'b0;
		if (cur == IDX_SEQL) begin
			if (head.grp) begin
				nxt = IDX_TOP;
			end else if (head.fin) begin
				nxt = IDX_CRC;
			end else begin
				done = 1'b1;
			end
		end else if (cur >= IDX_G0 && cur <= IDX_G6) begin
			if ({1'b0, k} + 4'd1 >= {1'b0, head.cnt}) begin
				nxt = IDX_CRC;
				done = !head.fin;
			end
		end else if (cur == IDX_EOX) begin
			done = 1'b1;
		end
	end

	always_comb begin
		unique case (cur)
			IDX_SOX:  sel = SOX_BYTE;
			IDX_MFR:  sel = {1'b0, cfg.manufacturer_id};
			IDX_DEV:  sel = {1'b0, cfg.device_id};
			IDX_TYPE: sel = {1'b0, cfg.block_type};
			IDX_SEQH: sel = {1'b0, head.seq[13:7]};
			IDX_SEQL: sel = {1'b0, head.seq[6:0]};
			IDX_TOP:  sel = {1'b0, head.top};
			IDX_CRC:  sel = head.crc;
			IDX_EOX:  sel = EOX_BYTE;
			default:  sel = {1'b0, head.bytes[k]};
		endcase
	end

	assign emit = !empty && (!ov_q || out_ready);
	assign pop  = emit && done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mid_q <= 1'b0;
			idx_q <= IDX_SOX;
			ov_q  <= 1'b0;
		end else begin
			if (emit) begin
				ov_q  <= 1'b1;
				mid_q <= !done;
				idx_q <= nxt;
			end else if (out_ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			ob_q   <= sel;
			orun_q <= done;
			oend_q <= (cur == IDX_EOX);
		end
	end

	assign out_valid   = ov_q;
	assign out_byte    = ob_q;
	assign run_end     = orun_q;
	assign message_end = oend_q;

endmodule

[rtl/sysex_data_block_framer_top.sv]
// ----------------------------------------------------------------------------
// sysex_data_block_framer_top
// Frames a data block as a System Exclusive message with 7-bit packing and CRC-8.
// ----------------------------------------------------------------------------
// One raw byte is accepted per cycle while the command queue has room; a
// byte that opens a block, fills a group of seven or ends the block issues
// one command, and the back end sends one framed byte per cycle while the
// output is ready, so a long block goes out as eight bytes per group of
// seven, plus the header, CRC and F7. The rate is set by the single output
// byte per cycle of the back-end sequencer, when m_tready does not stall it.
module sysex_data_block_framer_top #(
	parameter int unsigned QUEUE_DEPTH = sdbf_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [sdbf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [sdbf_pkg::CFG_W-1:0]    cfg_data,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [23:0]                   s_tdata,  // data_byte[7:0], seq_number[21:8], zero
	input  logic                          s_tlast,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [7:0]                    m_tdata,  // out_byte[7:0]
	output logic                          m_tlast,
	output logic                          m_tuser   // message_end
);
	import sdbf_pkg::*;

	cfg_t cfg_q;
	cmd_t wr_cmd;
	cmd_t head;
	logic push;
	logic pop;
	logic empty;
	logic full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.manufacturer_id <= MANUFACTURER_RST;
			cfg_q.device_id       <= DEVICE_RST;
			cfg_q.block_type      <= BLOCK_TYPE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MANUFACTURER: cfg_q.manufacturer_id <= cfg_data;
				REG_DEVICE:       cfg_q.device_id       <= cfg_data;
				REG_BLOCK_TYPE:   cfg_q.block_type      <= cfg_data;
				default:          cfg_q                 <= cfg_q;
			endcase
		end
	end

	sdbf_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.data_byte  (s_tdata[7:0]),
		.seq_number (s_tdata[21:8]),
		.last_byte  (s_tlast),
		.q_full     (full),
		.push       (push),
		.cmd        (wr_cmd)
	);

	sdbf_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_cmd (wr_cmd),
		.pop    (pop),
		.head   (head),
		.empty  (empty),
		.full   (full)
	);

	sdbf_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.head        (head),
		.empty       (empty),
		.pop         (pop),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_byte    (m_tdata),
		.run_end     (m_tlast),
		.message_end (m_tuser)
	);

endmodule
